// File: rtl/core/hclp_pkg.sv
`timescale 1ns / 1ps

package hclp_pkg;

    // Default line capacity in characters, carriage return included
    localparam int BufferCharsDef = 32;

    // Character codes
    localparam logic [7:0] CharCr   = 8'd13;
    localparam logic [7:0] CharHash = 8'h23;
    localparam logic [7:0] CharNul  = 8'h00;
    localparam logic [7:0] Char0    = 8'h30;
    localparam logic [7:0] Char9    = 8'h39;
    localparam logic [7:0] CharUA   = 8'h41;
    localparam logic [7:0] CharUF   = 8'h46;
    localparam logic [7:0] CharLa   = 8'h61;
    localparam logic [7:0] CharLf   = 8'h66;

    localparam logic [2:0] DigitsNeeded = 3'd6;
    localparam logic [2:0] DigitsSat    = 3'd7;

    typedef enum logic [1:0] {
        KIND_ECHO   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] echo_byte;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_result;

    // Hex digit decode: bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'd0;
        if (ch >= Char0 && ch <= Char9) begin
            d = ch - Char0;
            return {1'b0, d[3:0]};
        end else if (ch >= CharUA && ch <= CharUF) begin
            d = ch - CharUA + 8'd10;
            return {1'b0, d[3:0]};
        end else if (ch >= CharLa && ch <= CharLf) begin
            d = ch - CharLa + 8'd10;
            return {1'b0, d[3:0]};
        end
        return 5'h10;
    endfunction

endpackage

// File: rtl/core/hclp_in_stage.sv
`timescale 1ns / 1ps

module hclp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tvalid,
    output logic       o_tready,
    input  logic [7:0] i_tdata,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Take a new byte when empty or when the held byte moves on
    assign o_tready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_byte <= i_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// File: rtl/core/hclp_core.sv
`timescale 1ns / 1ps

module hclp_core #(
    parameter int BUFFER_CHARS = hclp_pkg::BufferCharsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output hclp_pkg::t_result o_res
);
    import hclp_pkg::*;

    localparam int CntW = $clog2(BUFFER_CHARS);
    localparam logic [CntW-1:0] HeldMax = CntW'(BUFFER_CHARS - 1);

    logic [CntW-1:0] r_held;
    logic [2:0]      r_digits;
    logic [23:0]     r_acc;
    logic            r_bad;
    logic            r_ended;

    logic [CntW-1:0] n_held;
    logic [2:0]      n_digits;
    logic [23:0]     n_acc;
    logic            n_bad;
    logic            n_ended;

    logic            is_cr;
    logic            ok;
    logic [4:0]      nib;

    assign is_cr = (i_byte == CharCr);
    assign ok    = !r_bad && (r_digits == DigitsNeeded);
    assign nib   = hex_nibble(i_byte);

    // Judge the line on carriage return, otherwise parse and echo the byte unless the line is full
    always_comb begin
        n_held      = r_held;
        n_digits    = r_digits;
        n_acc       = r_acc;
        n_bad       = r_bad;
        n_ended     = r_ended;
        o_res_valid = 1'b1;
        o_res       = '{kind: KIND_ECHO, echo_byte: i_byte,
                        red: 8'd0, green: 8'd0, blue: 8'd0};
        if (is_cr) begin
            o_res.echo_byte = 8'd0;
            if (ok) begin
                o_res.kind  = KIND_ACCEPT;
                o_res.red   = r_acc[23:16];
                o_res.green = r_acc[15:8];
                o_res.blue  = r_acc[7:0];
            end else begin
                o_res.kind = KIND_REJECT;
            end
            n_held   = '0;
            n_digits = '0;
            n_acc    = '0;
            n_bad    = 1'b0;
            n_ended  = 1'b0;
        end else if (r_held == HeldMax) begin
            // Line full: drop silently
            o_res_valid = 1'b0;
        end else begin
            n_held = r_held + 1'b1;
            priority if (r_ended) begin
                n_ended = 1'b1;
            end else if (i_byte == CharNul) begin
                n_ended = 1'b1;
            end else if (r_held == '0 && i_byte == CharHash) begin
                n_ended = 1'b0;
            end else if (r_digits >= DigitsNeeded) begin
                n_digits = DigitsSat;
            end else if (nib[4]) begin
                n_bad = 1'b1;
            end else begin
                n_acc    = {r_acc[19:0], nib[3:0]};
                n_digits = r_digits + 3'd1;
            end
        end
    end

    // Hold line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_digits <= '0;
            r_acc    <= '0;
            r_bad    <= 1'b0;
            r_ended  <= 1'b0;
        end else if (i_step) begin
            r_held   <= n_held;
            r_digits <= n_digits;
            r_acc    <= n_acc;
            r_bad    <= n_bad;
            r_ended  <= n_ended;
        end
    end

endmodule

// File: rtl/core/hex_color_line_parser.sv
`timescale 1ns / 1ps

// Hex color line parser. Takes one received byte per transfer on the slave
// side and gives at most one result per byte on the master side: an echo of
// each byte kept on the line, and on carriage return either the accepted
// red, green and blue levels or a rejection. A line is an optional leading
// '#' and exactly six hex digits, with any bytes after a NUL byte ignored;
// bytes past BUFFER_CHARS-1 are dropped without a result. A byte passes an
// input register, combinational parse logic and a result register; a byte can
// be taken every cycle as long as the master side keeps taking results.
module hex_color_line_parser #(
    parameter int BUFFER_CHARS = hclp_pkg::BufferCharsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] echo_byte, [15:8] red,
                                     // [23:16] green, [31:24] blue
    output logic [1:0]  o_m_tuser    // [1:0] result_kind
);
    import hclp_pkg::*;

    logic    in_valid;
    logic [7:0] in_byte;
    logic    advance;
    logic    res_valid;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    // Move the held byte on when the result register is free or draining
    assign advance = in_valid && (!r_out_valid || i_m_tready);

    hclp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_tvalid),
        .o_tready  (o_s_tready),
        .i_tdata   (i_s_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    hclp_core #(
        .BUFFER_CHARS (BUFFER_CHARS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {r_out.blue, r_out.green, r_out.red, r_out.echo_byte};

endmodule

// File: rtl/core/hclp_checker.sv
`timescale 1ns / 1ps

module hclp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);
    import hclp_pkg::*;

    // No result right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // Only the three defined kinds appear
    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == KIND_ECHO || o_m_tuser == KIND_ACCEPT ||
                        o_m_tuser == KIND_REJECT))
        else $error("undefined result kind");

    // An echo carries no color, a verdict carries no echo byte
    a_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == KIND_ECHO && o_m_tdata[31:8] == 24'd0) ||
                        (o_m_tuser != KIND_ECHO && o_m_tdata[7:0] == 8'd0)))
        else $error("stray bits in result fields");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind hex_color_line_parser hclp_checker u_hclp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
